@@ rtl/core/byte_stream_tokenizer_top_macros.svh @@
// Assertion macros for the tokenizer; define ASSERT_OFF to drop them.
`ifndef BYTE_STREAM_TOKENIZER_TOP_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define BST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/core/bst_pkg.sv @@
`default_nettype none
package bst_pkg;

  localparam int unsigned POS_BITS_DEF = 32;
  localparam int unsigned OUT_BITS     = 32;
  localparam int unsigned EXT_BITS     = 64;
  localparam int unsigned RES_MAX      = 3;
  localparam int unsigned CAND_N       = 4;
  localparam int unsigned FIFO_DEPTH   = 8;
  localparam int unsigned PTR_BITS     = 3;
  localparam int unsigned LVL_BITS     = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_NUMBER  = 4'd2,
    KIND_STRING  = 4'd3,
    KIND_LPAREN  = 4'd4,
    KIND_RPAREN  = 4'd5,
    KIND_LBRACE  = 4'd6,
    KIND_RBRACE  = 4'd7,
    KIND_COLON   = 4'd8,
    KIND_SEMI    = 4'd9,
    KIND_PERCENT = 4'd10,
    KIND_COMMA   = 4'd11,
    KIND_UNKNOWN = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       no_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_t                token_kind;
    logic [OUT_BITS-1:0]  start_offset;
    logic [OUT_BITS-1:0]  text_length;
    logic                 last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0]               cnt;
    tok_t [RES_MAX-1:0]       toks;
  } push_t;

  typedef struct packed {
    logic                room;
    logic [LVL_BITS-1:0] level;
  } fifo_st_t;

  function automatic logic is_space(logic [7:0] b);
    is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    is_digit = (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    is_alpha = (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
  endfunction

  function automatic logic is_ident_cont(logic [7:0] b);
    is_ident_cont = is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  // Mode entered when a byte is scanned from idle.
  function automatic mode_t start_mode(logic [7:0] b);
    if (b == CH_SLASH) begin
      start_mode = MODE_SLASH;
    end else if (is_alpha(b) || b == CH_UNDER) begin
      start_mode = MODE_IDENT;
    end else if (is_digit(b)) begin
      start_mode = MODE_NUMBER;
    end else if (b == CH_QUOTE) begin
      start_mode = MODE_STRING;
    end else begin
      start_mode = MODE_IDLE;
    end
  endfunction

  // Byte scanned from idle that is a one-byte token on its own.
  function automatic logic is_single(logic [7:0] b);
    is_single = !is_space(b) && (start_mode(b) == MODE_IDLE);
  endfunction

  function automatic kind_t single_kind(logic [7:0] b);
    unique case (b)
      CH_LPAREN: single_kind = KIND_LPAREN;
      CH_RPAREN: single_kind = KIND_RPAREN;
      CH_LBRACE: single_kind = KIND_LBRACE;
      CH_RBRACE: single_kind = KIND_RBRACE;
      CH_COLON:  single_kind = KIND_COLON;
      CH_SEMI:   single_kind = KIND_SEMI;
      CH_PCT:    single_kind = KIND_PERCENT;
      CH_COMMA:  single_kind = KIND_COMMA;
      default:   single_kind = KIND_UNKNOWN;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/bst_lexer.sv @@
`default_nettype none
module bst_lexer import bst_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     room,
  output push_t    push
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  function automatic logic [OUT_BITS-1:0] sat_out(logic [POS_BITS-1:0] v);
    logic [EXT_BITS-1:0] w;
    w = EXT_BITS'(v);
    sat_out = (|w[EXT_BITS-1:OUT_BITS]) ? '1 : w[OUT_BITS-1:0];
  endfunction

  function automatic logic [POS_BITS-1:0] sat_sub(logic [POS_BITS-1:0] a,
                                                  logic [POS_BITS-1:0] b);
    sat_sub = (a > b) ? a - b : '0;
  endfunction

  in_word_t            in_r;
  logic                in_vld_r;
  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] tstart_r, tstart_nxt;

  logic                advance;
  logic [7:0]          b;
  logic                has_byte;
  logic                last;
  logic                restart;
  mode_t               mode_b;
  logic [POS_BITS-1:0] tstart_b;
  logic [POS_BITS-1:0] pos_b;

  logic                close_v;
  kind_t               close_kind;
  logic [POS_BITS-1:0] close_start;
  logic [POS_BITS-1:0] close_len;
  logic                flush_v;
  kind_t               flush_kind;
  logic [POS_BITS-1:0] flush_len;
  logic [POS_BITS-1:0] str_len;
  logic                cand_v [CAND_N];
  tok_t                cand   [CAND_N];
  logic [1:0]          n;
  tok_t [RES_MAX-1:0]  toks;

  assign advance  = in_vld_r && room;
  assign in_stall = in_vld_r && !advance;
  assign b        = in_r.in_byte;
  assign has_byte = !in_r.no_byte;
  assign last     = in_r.end_of_input;
  assign pos_b    = (has_byte && pos_r != POS_MAX) ? pos_r + POS_ONE : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
    end
  end

  // Next scan state for the held word.
  always_comb begin
    restart  = 1'b0;
    mode_b   = mode_r;
    tstart_b = tstart_r;
    if (has_byte) begin
      unique case (mode_r)
        MODE_IDENT:  restart = !is_ident_cont(b);
        MODE_NUMBER: restart = !is_digit(b);
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            mode_b = MODE_IDLE;
          end else if (b == CH_NUL) begin
            restart = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            mode_b = MODE_COMMENT;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (b == CH_LF) begin
            mode_b = MODE_IDLE;
          end else if (b == CH_NUL) begin
            restart = 1'b1;
          end
        end
        MODE_IDLE: restart = 1'b1;
        default:   restart = 1'b1;
      endcase
      if (restart) begin
        mode_b = start_mode(b);
        if (!is_space(b)) begin
          tstart_b = pos_r;
        end
      end
    end
    if (last) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      tstart_nxt = '0;
    end else begin
      mode_nxt   = mode_b;
      pos_nxt    = pos_b;
      tstart_nxt = tstart_b;
    end
  end

  // Tokens closed by the byte, the byte's own token, the flush and EOF.
  always_comb begin
    str_len     = sat_sub(sat_sub(pos_r, tstart_r), POS_ONE);
    close_v     = 1'b0;
    close_kind  = KIND_UNKNOWN;
    close_start = tstart_r;
    close_len   = sat_sub(pos_r, tstart_r);
    if (has_byte) begin
      unique case (mode_r)
        MODE_IDENT: begin
          close_v    = !is_ident_cont(b);
          close_kind = KIND_IDENT;
        end
        MODE_NUMBER: begin
          close_v    = !is_digit(b);
          close_kind = KIND_NUMBER;
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            close_v     = 1'b1;
            close_kind  = KIND_STRING;
            close_start = (tstart_r != POS_MAX) ? tstart_r + POS_ONE : tstart_r;
            close_len   = str_len;
          end else if (b == CH_NUL) begin
            close_v = 1'b1;
          end
        end
        MODE_SLASH: begin
          close_v   = (b != CH_SLASH);
          close_len = POS_ONE;
        end
        MODE_IDLE, MODE_COMMENT: close_v = 1'b0;
        default:                 close_v = 1'b0;
      endcase
    end

    flush_v    = 1'b0;
    flush_kind = KIND_UNKNOWN;
    flush_len  = sat_sub(pos_b, tstart_b);
    if (last) begin
      unique case (mode_b)
        MODE_IDENT: begin
          flush_v    = 1'b1;
          flush_kind = KIND_IDENT;
        end
        MODE_NUMBER: begin
          flush_v    = 1'b1;
          flush_kind = KIND_NUMBER;
        end
        MODE_STRING: flush_v = 1'b1;
        MODE_SLASH: begin
          flush_v   = 1'b1;
          flush_len = POS_ONE;
        end
        MODE_IDLE, MODE_COMMENT: flush_v = 1'b0;
        default:                 flush_v = 1'b0;
      endcase
    end

    cand_v[0] = close_v;
    cand[0]   = '{token_kind: close_kind, start_offset: sat_out(close_start),
                  text_length: sat_out(close_len), last_of_run: 1'b0};
    cand_v[1] = restart && is_single(b);
    cand[1]   = '{token_kind: single_kind(b), start_offset: sat_out(pos_r),
                  text_length: OUT_BITS'(1), last_of_run: 1'b0};
    cand_v[2] = flush_v;
    cand[2]   = '{token_kind: flush_kind, start_offset: sat_out(tstart_b),
                  text_length: sat_out(flush_len), last_of_run: 1'b0};
    cand_v[3] = last;
    cand[3]   = '{token_kind: KIND_EOF, start_offset: sat_out(pos_b),
                  text_length: '0, last_of_run: 1'b0};

    // Pack the valid candidates in order, mark the final one.
    n    = '0;
    toks = '0;
    for (int i = 0; i < CAND_N; i++) begin
      if (cand_v[i] && n != 2'(RES_MAX)) begin
        toks[n] = cand[i];
        n       = n + 2'd1;
      end
    end
    if (n != '0) begin
      toks[n - 2'd1].last_of_run = 1'b1;
    end
  end

  assign push.cnt  = advance ? n : '0;
  assign push.toks = toks;

endmodule
`default_nettype wire

@@ rtl/core/bst_result_fifo.sv @@
`default_nettype none
module bst_result_fifo import bst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  push_t    push,
  output logic     out_valid,
  input  logic     out_stall,
  output tok_t     out_data,
  output fifo_st_t fifo_st
);

  localparam logic [LVL_BITS-1:0] ROOM_LVL = LVL_BITS'(FIFO_DEPTH - RES_MAX);

  tok_t                mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_BITS-1:0] level_r, level_nxt;
  logic                pop;

  assign out_valid     = (level_r != '0);
  assign out_data      = mem_r[rd_ptr_r];
  assign pop           = out_valid && !out_stall;
  assign fifo_st.room  = (level_r <= ROOM_LVL);
  assign fifo_st.level = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_BITS'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_BITS'(1) : rd_ptr_r;
    level_nxt  = level_r + LVL_BITS'(push.cnt) - LVL_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wr_ptr_r + PTR_BITS'(i)] <= push.toks[i];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/byte_stream_tokenizer_top.sv @@
`default_nettype none
`include "byte_stream_tokenizer_top_macros.svh"
// Streaming tokenizer: one byte per input word, tokens out as kind, start offset
// and length. A word is taken into an input register, scanned there, and its up
// to three tokens are written at once into an eight-entry result queue, from
// which one token leaves per cycle while out_stall is low; the first token of a
// word passes the input register and then the queue before it reaches out_.
// Input runs at one word per cycle as long as the queue holds five or fewer
// tokens; the output side drains one token a cycle while out_stall is low, so
// text averaging no more than one token per byte streams without stalls and
// bursts of two or three tokens are absorbed by the queue.
module byte_stream_tokenizer_top import bst_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tok_t     out_data
);

  push_t    push;
  fifo_st_t fifo_st;

  bst_lexer #(
    .POS_BITS (POS_BITS)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (fifo_st.room),
    .push     (push)
  );

  bst_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fifo_st   (fifo_st)
  );

  `BST_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1,
                  fifo_st.level <= LVL_BITS'(FIFO_DEPTH), "result queue overflow")
  `BST_ASSERT_IMP(a_push_fits, clk, rst_n, push.cnt != 2'd0,
                  fifo_st.room && push.cnt <= 2'(RES_MAX), "push without room")
  `BST_ASSERT_IMP(a_eof_last, clk, rst_n, out_valid && out_data.token_kind == KIND_EOF,
                  out_data.last_of_run && out_data.text_length == '0,
                  "EOF word not last or has length")
  `BST_ASSERT_NXT(a_drain, clk, rst_n,
                  out_valid && !out_stall && fifo_st.level == LVL_BITS'(1)
                  && push.cnt == 2'd0, !out_valid, "queue failed to drain")

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bst_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 32;
  localparam int RAND_WORDS  = 230;
  localparam int QUIET_WORDS = 40;
  localparam logic [63:0] POS_MAX = {64{1'b1}} >> (64 - POS_BITS_DEF);

  localparam logic [7:0] SINGLE_CH [8] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                          CH_COLON, CH_SEMI, CH_PCT, CH_COMMA};

  // One line of the directed table; k/s/l only mean something when typed is set.
  typedef struct packed {
    logic [7:0]  b;
    logic        nb;
    logic        eoi;
    logic        typed;
    kind_t       k;
    logic [31:0] s;
    logic [31:0] l;
  } drow_t;

  localparam int DIR_N = 27;
  localparam drow_t DIRECTED [DIR_N] = '{
    '{CH_LPAREN, 1'b0, 1'b0, 1'b1, KIND_LPAREN,  32'd0, 32'd1},
    '{CH_RPAREN, 1'b0, 1'b0, 1'b1, KIND_RPAREN,  32'd1, 32'd1},
    '{CH_LBRACE, 1'b0, 1'b0, 1'b1, KIND_LBRACE,  32'd2, 32'd1},
    '{CH_RBRACE, 1'b0, 1'b0, 1'b1, KIND_RBRACE,  32'd3, 32'd1},
    '{CH_COLON,  1'b0, 1'b0, 1'b1, KIND_COLON,   32'd4, 32'd1},
    '{CH_SEMI,   1'b0, 1'b0, 1'b1, KIND_SEMI,    32'd5, 32'd1},
    '{CH_PCT,    1'b0, 1'b0, 1'b1, KIND_PERCENT, 32'd6, 32'd1},
    '{CH_COMMA,  1'b0, 1'b0, 1'b1, KIND_COMMA,   32'd7, 32'd1},
    '{CH_NUL,    1'b0, 1'b0, 1'b1, KIND_UNKNOWN, 32'd8, 32'd1},
    '{8'hFF,     1'b0, 1'b0, 1'b1, KIND_UNKNOWN, 32'd9, 32'd1},
    '{CH_TAB,    1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_LA,     1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_9,      1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_0,      1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_NUL,    1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_NUL,    1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{8'hA5,     1'b1, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b1, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{8'h5A,     1'b1, 1'b1, 1'b1, KIND_EOF,     32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, KIND_EOF,     32'd0, 32'd0},
    '{CH_SLASH,  1'b0, 1'b1, 1'b0, KIND_EOF,     32'd0, 32'd0}
  };

  typedef struct {
    in_word_t w;
    logic     typed;
    tok_t     tok;
  } row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_word_t in_data;
  logic     out_valid;
  logic     out_stall;
  tok_t     out_data;

  row_t rows[$];
  tok_t pending_toks[$];
  tok_t fresh_toks[$];

  int sent = 0;
  int checked = 0;
  int inputs_ended = 0;
  int errors = 0;
  int real_words = 0;
  int in_gap = 0;
  int out_gap = 0;
  int stuck = 0;

  // Scanner state of the predictor
  mode_t       scan_st = MODE_IDLE;
  logic [63:0] cur_pos = '0;
  logic [63:0] tok_start = '0;

  always #2 clk = ~clk;

  byte_stream_tokenizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic logic cls_space(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic cls_digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic logic cls_alpha(logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
  endfunction

  function automatic kind_t byte_kind(logic [7:0] b);
    case (b)
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_COLON:  return KIND_COLON;
      CH_SEMI:   return KIND_SEMI;
      CH_PCT:    return KIND_PERCENT;
      CH_COMMA:  return KIND_COMMA;
      default:   return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic logic [31:0] sat_hi(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [63:0] floor_sub(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  task automatic emit_tok(kind_t k, logic [63:0] s, logic [63:0] l);
    tok_t t;
    if (fresh_toks.size() < RES_MAX) begin
      t.token_kind   = k;
      t.start_offset = sat_hi(s);
      t.text_length  = sat_hi(l);
      t.last_of_run  = 1'b0;
      fresh_toks.insert(fresh_toks.size(), t);
    end
  endtask

  // Scan a byte from between tokens
  task automatic open_token(logic [7:0] b, logic [63:0] p);
    scan_st = MODE_IDLE;
    if (!cls_space(b)) begin
      tok_start = p;
      if (b == CH_SLASH) begin
        scan_st = MODE_SLASH;
      end else if (cls_alpha(b) || b == CH_UNDER) begin
        scan_st = MODE_IDENT;
      end else if (cls_digit(b)) begin
        scan_st = MODE_NUMBER;
      end else if (b == CH_QUOTE) begin
        scan_st = MODE_STRING;
      end else begin
        emit_tok(byte_kind(b), p, 64'd1);
      end
    end
  endtask

  task automatic take_byte(logic [7:0] b, logic [63:0] p);
    case (scan_st)
      MODE_IDENT: begin
        if (!(cls_alpha(b) || cls_digit(b) || b == CH_UNDER)) begin
          emit_tok(KIND_IDENT, tok_start, floor_sub(p, tok_start));
          open_token(b, p);
        end
      end
      MODE_NUMBER: begin
        if (!cls_digit(b)) begin
          emit_tok(KIND_NUMBER, tok_start, floor_sub(p, tok_start));
          open_token(b, p);
        end
      end
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          // text starts after the opening quote
          emit_tok(KIND_STRING, (tok_start < POS_MAX) ? tok_start + 64'd1 : tok_start,
                   floor_sub(floor_sub(p, tok_start), 64'd1));
          scan_st = MODE_IDLE;
        end else if (b == CH_NUL) begin
          // cut short: report from the quote, then rescan the NUL
          emit_tok(KIND_UNKNOWN, tok_start, floor_sub(p, tok_start));
          open_token(b, p);
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          scan_st = MODE_COMMENT;
        end else begin
          emit_tok(KIND_UNKNOWN, tok_start, 64'd1);
          open_token(b, p);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_LF) begin
          scan_st = MODE_IDLE;
        end else if (b == CH_NUL) begin
          open_token(b, p);
        end
      end
      default: open_token(b, p);
    endcase
  endtask

  task automatic flush_input();
    case (scan_st)
      MODE_IDENT:  emit_tok(KIND_IDENT, tok_start, floor_sub(cur_pos, tok_start));
      MODE_NUMBER: emit_tok(KIND_NUMBER, tok_start, floor_sub(cur_pos, tok_start));
      MODE_STRING: emit_tok(KIND_UNKNOWN, tok_start, floor_sub(cur_pos, tok_start));
      MODE_SLASH:  emit_tok(KIND_UNKNOWN, tok_start, 64'd1);
      default: ;
    endcase
    emit_tok(KIND_EOF, cur_pos, 64'd0);
    scan_st   = MODE_IDLE;
    cur_pos   = '0;
    tok_start = '0;
  endtask

  // Work out the tokens one accepted word gives, into fresh_toks
  task automatic scan_word(in_word_t w);
    fresh_toks.delete();
    if (!w.no_byte) begin
      take_byte(w.in_byte, cur_pos);
      if (cur_pos < POS_MAX) cur_pos = cur_pos + 64'd1;
    end
    if (w.end_of_input) flush_input();
    if (fresh_toks.size() > 0) fresh_toks[fresh_toks.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic add_word(logic [7:0] b, logic nb, logic eoi);
    row_t r;
    r.w.in_byte      = b;
    r.w.no_byte      = nb;
    r.w.end_of_input = eoi;
    r.typed          = 1'b0;
    r.tok            = '0;
    rows.insert(rows.size(), r);
    if (!(nb && !eoi)) real_words++;
  endtask

  function automatic logic [7:0] ident_char(logic first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return CH_LA + 8'(r);
    if (r < 52) return CH_UA + 8'(r - 26);
    if (r == 52) return CH_UNDER;
    return CH_0 + 8'(r - 53);
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == CH_QUOTE) ? CH_UNDER : c;
  endfunction

  // Mostly well-formed fragments with random content, some noise
  task automatic add_fragment();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      add_word(ident_char(1'b1), 1'b0, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) add_word(ident_char(1'b0), 1'b0, 1'b0);
    end else if (pick < 36) begin
      n = $urandom_range(1, 5);
      repeat (n) add_word(CH_0 + 8'($urandom_range(0, 9)), 1'b0, 1'b0);
    end else if (pick < 48) begin
      add_word(CH_QUOTE, 1'b0, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) add_word(text_char(), 1'b0, 1'b0);
      n = $urandom_range(0, 9);
      if (n < 7) add_word(CH_QUOTE, 1'b0, 1'b0);
      else if (n < 9) add_word(CH_NUL, 1'b0, 1'b0);
    end else if (pick < 56) begin
      add_word(CH_SLASH, 1'b0, 1'b0);
      add_word(CH_SLASH, 1'b0, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) add_word(text_char(), 1'b0, 1'b0);
      n = $urandom_range(0, 9);
      if (n < 7) add_word(CH_LF, 1'b0, 1'b0);
      else if (n < 9) add_word(CH_NUL, 1'b0, 1'b0);
    end else if (pick < 70) begin
      add_word(SINGLE_CH[$urandom_range(0, 7)], 1'b0, 1'b0);
    end else if (pick < 82) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        pick = $urandom_range(0, 5);
        add_word((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick), 1'b0, 1'b0);
      end
    end else if (pick < 86) begin
      add_word(CH_SLASH, 1'b0, 1'b0);
    end else if (pick < 94) begin
      add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else begin
      add_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
  endtask

  task automatic build_stimulus();
    row_t r;
    foreach (DIRECTED[i]) begin
      r.w.in_byte          = DIRECTED[i].b;
      r.w.no_byte          = DIRECTED[i].nb;
      r.w.end_of_input     = DIRECTED[i].eoi;
      r.typed              = DIRECTED[i].typed;
      r.tok.token_kind     = DIRECTED[i].k;
      r.tok.start_offset   = DIRECTED[i].s;
      r.tok.text_length    = DIRECTED[i].l;
      r.tok.last_of_run    = 1'b1;
      rows.insert(rows.size(), r);
    end
    real_words = 0;
    while (real_words < RAND_WORDS) begin
      add_fragment();
      if ($urandom_range(0, 13) == 0) begin
        // end the input on the last byte, or with a word of its own
        if ($urandom_range(0, 1) == 1 && !rows[$].w.no_byte && !rows[$].w.end_of_input)
          rows[rows.size() - 1].w.end_of_input = 1'b1;
        else
          add_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
    end
    add_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  always @(posedge clk) begin
    tok_t want;
    logic quiet;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        scan_word(in_data);
        if (rows[sent].typed) begin
          pending_toks.insert(pending_toks.size(), rows[sent].tok);
        end else begin
          foreach (fresh_toks[j]) pending_toks.insert(pending_toks.size(), fresh_toks[j]);
        end
        if (in_data.end_of_input) inputs_ended++;
        sent++;
      end

      if (out_valid && !out_stall) begin
        if (pending_toks.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected token: kind %0d start %0d len %0d last %0b",
                     out_data.token_kind, out_data.start_offset, out_data.text_length,
                     out_data.last_of_run);
        end else begin
          want = pending_toks.pop_front();
          checked++;
          if (out_data.token_kind !== want.token_kind ||
              out_data.start_offset !== want.start_offset ||
              out_data.text_length !== want.text_length ||
              out_data.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= 10)
              $display({"token %0d: expected kind %0d start %0d len %0d last %0b, ",
                        "got %0d %0d %0d %0b"},
                       checked, want.token_kind, want.start_offset, want.text_length,
                       want.last_of_run, out_data.token_kind, out_data.start_offset,
                       out_data.text_length, out_data.last_of_run);
          end
        end
      end

      quiet = (sent + QUIET_WORDS >= rows.size());

      // hold a stalled word, otherwise gap or advance
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sent < rows.size()) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(1, 17) - 1;
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_data  <= rows[sent].w;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (sent < rows.size() || pending_toks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d words over %0d inputs, %0d tokens compared, %0d errors",
             sent, inputs_ended, checked, errors);
    if (errors == 0 && pending_toks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bst_pkg.sv
rtl/core/bst_lexer.sv
rtl/core/bst_result_fifo.sv
rtl/core/byte_stream_tokenizer_top.sv
sim/tb_top.sv
